// ----- design/hcte_pkg.sv -----
// ----------------------------------------------------------------------------
// hcte_pkg
// Shared types and constants for the code table encoder: request codes,
// field widths and the packer result bundle.
// ----------------------------------------------------------------------------
package hcte_pkg;

  localparam int SYM_W     = 8;
  localparam int SYM_COUNT = 256;
  localparam int PATH_W    = 32;
  localparam int LEN_W     = 6;
  localparam int MAX_LEN   = 32;
  localparam int BYTE_W    = 8;
  localparam int BITS_W    = 4;
  localparam int CNT_W     = 3;
  localparam int NB_W      = 3;
  localparam int PACK_W    = BYTE_W + MAX_LEN;
  localparam int ENTRY_W   = PATH_W + LEN_W;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  // packed bits after appending one code to the pending partial byte
  typedef struct packed {
    logic [PACK_W-1:0] data;
    logic [NB_W-1:0]   nbytes;
    logic [BYTE_W-1:0] pbyte;
    logic [CNT_W-1:0]  pcnt;
  } pack_t;

endpackage

// ----- design/huffman_code_table_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// huffman_code_table_encoder_unit
// Code table lookup and lsb-first bit packer with a byte output queue.
// ----------------------------------------------------------------------------
// encodes and flushes pass the lookup stage, then the output queue
// throughput: one word per cycle while out_stall is low and each word
//   gives at most one result; an n-byte encode holds the output register
//   until its bytes pop; loads write the table at accept and give no result
// reset: table entries all absent (one valid flop per entry), partial byte
//   and count zero, pipeline and output queue empty
module huffman_code_table_encoder_unit import hcte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [PATH_W-1:0] code_path,
  input  logic [LEN_W-1:0]  code_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [BITS_W-1:0] out_bits,
  output logic              last,
  output logic              status
);

  // code table
  logic [ENTRY_W-1:0] code_mem [SYM_COUNT];
  logic [SYM_COUNT-1:0] tab_vld;

  // lookup stage
  logic              s1_valid;
  req_t              s1_req;
  logic              s1_tvld;
  logic [ENTRY_W-1:0] s1_entry;

  // pending partial byte
  logic [BYTE_W-1:0] pbyte;
  logic [CNT_W-1:0]  pcnt;

  // output queue
  logic [PACK_W-1:0] obuf_data;
  logic [NB_W-1:0]   obuf_cnt;
  logic [BITS_W-1:0] obuf_bits;
  logic              obuf_status;

  req_t              in_req;
  logic              in_acc;
  logic              pop;
  logic              fire;
  logic              s1_present;
  logic [LEN_W-1:0]  len_sat;
  pack_t             pk;

  assign in_req   = req_t'(req_type);
  assign pop      = out_valid && !out_stall;
  assign fire     = s1_valid && (obuf_cnt == '0 || (obuf_cnt == NB_W'(1) && pop));
  assign in_stall = s1_valid && !fire;
  assign in_acc   = in_valid && !in_stall;
  assign len_sat  = (code_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : code_length;
  assign s1_present = s1_tvld && (s1_entry[LEN_W-1:0] != '0);

  assign out_valid = (obuf_cnt != '0);
  assign out_byte  = obuf_data[BYTE_W-1:0];
  assign out_bits  = obuf_bits;
  assign last      = (obuf_cnt == NB_W'(1));
  assign status    = obuf_status;

  hcte_packer u_packer (
    .pbyte (pbyte),
    .pcnt  (pcnt),
    .path  (s1_entry[ENTRY_W-1:LEN_W]),
    .len   (s1_entry[LEN_W-1:0]),
    .pk    (pk)
  );

  // table memory: write on load, registered read on encode
  always_ff @(posedge clk) begin
    if (in_acc && in_req == REQ_LOAD) begin
      code_mem[symbol] <= {code_path, len_sat};
    end
    if (in_acc && in_req == REQ_ENCODE) begin
      s1_entry <= code_mem[symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_vld <= '0;
    end else if (in_acc && in_req == REQ_LOAD) begin
      tab_vld[symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && (in_req == REQ_ENCODE || in_req == REQ_FLUSH)) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_req  <= in_req;
      s1_tvld <= tab_vld[symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_cnt <= '0;
      pbyte    <= '0;
      pcnt     <= '0;
    end else if (fire) begin
      unique case (s1_req)
        REQ_ENCODE: begin
          if (s1_present) begin
            obuf_data   <= pk.data;
            obuf_cnt    <= pk.nbytes;
            obuf_bits   <= BITS_W'(BYTE_W);
            obuf_status <= 1'b0;
            pbyte       <= pk.pbyte;
            pcnt        <= pk.pcnt;
          end else begin
            // absent symbol: error word, state untouched
            obuf_data   <= '0;
            obuf_cnt    <= NB_W'(1);
            obuf_bits   <= '0;
            obuf_status <= 1'b1;
          end
        end
        REQ_FLUSH: begin
          obuf_data   <= PACK_W'(pbyte);
          obuf_cnt    <= NB_W'(1);
          obuf_bits   <= BITS_W'(pcnt);
          obuf_status <= 1'b0;
          pbyte       <= '0;
          pcnt        <= '0;
        end
        default: begin
          obuf_cnt <= '0;
        end
      endcase
    end else if (pop) begin
      obuf_data <= obuf_data >> BYTE_W;
      obuf_cnt  <= obuf_cnt - NB_W'(1);
    end
  end

  // error words are always single and carry no bits
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && out_bits == '0)
    else $error("error word not final or carries bits");

  // only the final word of an item may be a partial byte or an error
  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> out_bits == BITS_W'(BYTE_W) && !status)
    else $error("non-final word is not a full byte");

  // input only stalls behind a held lookup stage and a busy output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a reason");

  // partial state moves only when an item leaves the lookup stage
  a_partial_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(pcnt) && $stable(pbyte))
    else $error("partial byte changed without an item");

endmodule

// ----- design/hcte_packer.sv -----
// ----------------------------------------------------------------------------
// hcte_packer
// Reverses a root-first code so its first bit sits at the lsb, appends it
// above the pending partial byte and splits off the completed bytes.
// ----------------------------------------------------------------------------
module hcte_packer import hcte_pkg::*; (
  input  logic [BYTE_W-1:0] pbyte,
  input  logic [CNT_W-1:0]  pcnt,
  input  logic [PATH_W-1:0] path,
  input  logic [LEN_W-1:0]  len,
  output pack_t             pk
);

  logic [PATH_W-1:0] rev;
  logic [PATH_W-1:0] code;
  logic [LEN_W-1:0]  rsh;
  logic [LEN_W-1:0]  total;
  logic [PACK_W-1:0] word;

  always_comb begin
    for (int i = 0; i < PATH_W; i++) begin
      rev[i] = path[PATH_W-1-i];
    end
    // shift out the reversed bits that came from above the code length
    rsh   = LEN_W'(MAX_LEN) - len;
    code  = rev >> rsh;
    word  = (PACK_W'(code) << pcnt) | PACK_W'(pbyte);
    total = LEN_W'(pcnt) + len;
    pk.data   = word;
    pk.nbytes = total[LEN_W-1:CNT_W];
    pk.pcnt   = total[CNT_W-1:0];
    pk.pbyte  = BYTE_W'(word >> {pk.nbytes, 3'b000});
  end

endmodule
